/* hw/rtl/cst_pkg.sv */
// types, constants and lookup tables for the c subset token scanner
`timescale 1ns / 1ps
`default_nettype none

package cst_pkg;

	localparam int POSITION_BITS_DEF    = 16;
	localparam int MAX_TOKEN_LENGTH_DEF = 255;

	// result queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef enum logic [2:0] {
		MODE_IDLE   = 3'd0,
		MODE_STRING = 3'd1,
		MODE_WORD   = 3'd2,
		MODE_NUMBER = 3'd3,
		MODE_LT     = 3'd4,
		MODE_GT     = 3'd5,
		MODE_COLON  = 3'd6,
		MODE_HALT   = 3'd7
	} mode_t;

	typedef enum logic [2:0] {
		KIND_STRING  = 3'd0,
		KIND_KEYWORD = 3'd1,
		KIND_LISTED  = 3'd2,
		KIND_IDENT   = 3'd3,
		KIND_NUMBER  = 3'd4,
		KIND_PUNCT   = 3'd5,
		KIND_ERROR   = 3'd6
	} kind_t;

	// punctuator codes that the scanner writes directly
	localparam logic [4:0] PC_LT     = 5'd15;
	localparam logic [4:0] PC_GT     = 5'd16;
	localparam logic [4:0] PC_COLON  = 5'd20;
	localparam logic [4:0] PC_LE     = 5'd25;
	localparam logic [4:0] PC_GE     = 5'd26;
	localparam logic [4:0] PC_NE     = 5'd27;
	localparam logic [4:0] PC_ASSIGN = 5'd28;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam int NUM_NAMES    = 8;
	localparam int NUM_KEYWORDS = 6;
	localparam int NUM_PUNCT    = 25;

	localparam logic [7:0] ALIVE_ALL = 8'hFF;

	// keywords int void if else for return, then listed names main scanf
	localparam logic [7:0] NAME_TEXT [0:NUM_NAMES-1][0:7] = '{
		'{"i", "n", "t", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"v", "o", "i", "d", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"i", "f", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"e", "l", "s", "e", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"f", "o", "r", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"r", "e", "t", "u", "r", "n", CH_NUL, CH_NUL},
		'{"m", "a", "i", "n", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
		'{"s", "c", "a", "n", "f", CH_NUL, CH_NUL, CH_NUL}
	};

	localparam logic [2:0] NAME_LEN [0:NUM_NAMES-1] = '{
		3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd6, 3'd4, 3'd5
	};

	localparam logic [7:0] PUNCT_CHARS [0:NUM_PUNCT-1] = '{
		"[", "]", "(", ")", "{", "}", ".", "&", "*", "+", "-", "~", "!",
		"/", "%", "<", ">", "^", "|", "?", ":", ";", "=", ",", "#"
	};

	typedef struct packed {
		kind_t       kind;
		logic [4:0]  code;
		logic [15:0] start;
		logic [7:0]  length;
	} tok_t;

	typedef struct packed {
		logic valid;
		tok_t tok;
	} slot_t;

	typedef struct packed {
		tok_t tok;
		logic last;
	} entry_t;

	typedef struct packed {
		logic       valid;
		logic [4:0] code;
	} punct_t;

	function automatic punct_t punct_lookup(input logic [7:0] c);
		punct_t p;
		p.valid = 1'b0;
		p.code  = 5'd0;
		for (int k = 0; k < NUM_PUNCT; k++) begin
			if (!p.valid && PUNCT_CHARS[k] == c) begin
				p.valid = 1'b1;
				p.code  = 5'(k);
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/c_subset_token_scanner.sv */
// top level of the c subset token scanner: input register, scan logic, result queue
//
// usage: source text enters on the s_ channel, one character per word, with
// s_tdata[7:0] the character code and s_tlast marking the final character of a
// text (pending token is flushed and the offset counter restarts at zero).
// tokens leave on the m_ channel, one token per word; m_tlast marks the last
// token caused by one input character. a character causes zero, one or two
// tokens.
// a character accepted on the s_ channel is held in the input register, scanned
// from there, and its tokens are written into the result queue, whose head is
// offered on the m_ channel.
// throughput: one character per cycle while s_tready is high; the output side
// moves one token per cycle, so characters that give two tokens take two output
// words. the scan state is updated by combinational logic, and s_tready follows
// the free space in the eight-entry result queue.
// when the receiver stalls the queue fills and s_tready drops; nothing is lost.
// reset clears the scan state to idle, the offset to zero and empties the
// queue. after an error the scanner drops all input until reset.
`timescale 1ns / 1ps
`default_nettype none

module c_subset_token_scanner #(
	parameter int POSITION_BITS    = cst_pkg::POSITION_BITS_DEF,
	parameter int MAX_TOKEN_LENGTH = cst_pkg::MAX_TOKEN_LENGTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] char_code
	input  wire logic        s_tlast,   // end_of_text
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // [2:0] kind, [7:3] code, [23:8] start, [31:24] length
	output logic             m_tlast    // last_of_item
);

	import cst_pkg::*;

	localparam int PB   = POSITION_BITS;
	localparam int CW   = $clog2(MAX_TOKEN_LENGTH + 1);
	localparam int CNTW = FIFO_AW + 1;
	localparam int RDYW = CNTW + 1;

	// input register
	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        eot_s1;

	// scan state
	mode_t          mode_q, mode_d;
	logic [PB-1:0]  pos_q, pos_d;
	logic [PB-1:0]  begin_q, begin_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [7:0]     alive_q, alive_d;

	slot_t       slot_a, slot_b, slot_c;
	logic        done;
	logic        is_letter, is_digit;
	logic [4:0]  pair_code;
	logic        pair_hit;
	punct_t      pl;

	entry_t      first_e, second_e;
	logic [1:0]  n_push;

	// result queue
	entry_t              fifo_q [0:FIFO_DEPTH-1];
	logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]     count_q;
	logic                pop;
	entry_t              head;

	function automatic tok_t mk_tok(input kind_t k, input logic [4:0] code,
			input logic [PB-1:0] st, input logic [CW-1:0] n);
		tok_t        t;
		logic [31:0] st_w;
		logic [15:0] n_w;
		st_w     = 32'(st);
		n_w      = 16'(n);
		t.kind   = k;
		t.code   = code;
		t.start  = st_w[15:0];
		t.length = (n_w > 16'd255) ? 8'hFF : n_w[7:0];
		return t;
	endfunction

	function automatic logic [7:0] match_alive(input logic [7:0] al,
			input logic [CW-1:0] idx, input logic [7:0] c);
		logic [7:0] r;
		r = al;
		for (int k = 0; k < NUM_NAMES; k++) begin
			if (16'(idx) >= 16'd8 || NAME_TEXT[k][idx[2:0]] != c)
				r[k] = 1'b0;
		end
		return r;
	endfunction

	// pending token of a word, number or lone punctuator
	function automatic slot_t flush_tok(input mode_t m, input logic [PB-1:0] b,
			input logic [CW-1:0] n, input logic [7:0] al);
		slot_t s;
		logic  found;
		s.valid = 1'b0;
		s.tok   = mk_tok(KIND_IDENT, 5'd0, b, n);
		found   = 1'b0;
		unique case (m)
			MODE_WORD: begin
				s.valid = 1'b1;
				for (int k = 0; k < NUM_NAMES; k++) begin
					if (!found && al[k] && 16'(n) == 16'(NAME_LEN[k])) begin
						found = 1'b1;
						if (k < NUM_KEYWORDS)
							s.tok = mk_tok(KIND_KEYWORD, 5'(k), b, n);
						else
							s.tok = mk_tok(KIND_LISTED, 5'(k - NUM_KEYWORDS), b, n);
					end
				end
			end
			MODE_NUMBER: begin
				s.valid = 1'b1;
				s.tok   = mk_tok(KIND_NUMBER, 5'd0, b, n);
			end
			MODE_LT: begin
				s.valid = 1'b1;
				s.tok   = mk_tok(KIND_PUNCT, PC_LT, b, CW'(1));
			end
			MODE_GT: begin
				s.valid = 1'b1;
				s.tok   = mk_tok(KIND_PUNCT, PC_GT, b, CW'(1));
			end
			MODE_COLON: begin
				s.valid = 1'b1;
				s.tok   = mk_tok(KIND_PUNCT, PC_COLON, b, CW'(1));
			end
			default: ;
		endcase
		return s;
	endfunction

	function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] n);
		return (n < CW'(MAX_TOKEN_LENGTH)) ? n + CW'(1) : n;
	endfunction

	assign is_letter = (char_s1 >= "a" && char_s1 <= "z") || (char_s1 >= "A" && char_s1 <= "Z");
	assign is_digit  = (char_s1 >= "0" && char_s1 <= "9");
	assign pl        = punct_lookup(char_s1);

	always_comb begin
		pair_hit  = 1'b1;
		pair_code = PC_LE;
		priority if (mode_q == MODE_LT && char_s1 == CH_EQ)
			pair_code = PC_LE;
		else if (mode_q == MODE_GT && char_s1 == CH_EQ)
			pair_code = PC_GE;
		else if (mode_q == MODE_LT && char_s1 == CH_GT)
			pair_code = PC_NE;
		else if (mode_q == MODE_COLON && char_s1 == CH_EQ)
			pair_code = PC_ASSIGN;
		else
			pair_hit = 1'b0;
	end

	// one character of scanning; slot a from the open token, b from a fresh
	// start, c from the end-of-text flush
	always_comb begin
		mode_d  = mode_q;
		begin_d = begin_q;
		cnt_d   = cnt_q;
		alive_d = alive_q;
		pos_d   = pos_q;
		done    = 1'b0;
		slot_a  = '0;
		slot_b  = '0;
		slot_c  = '0;
		if (mode_q != MODE_HALT) begin
			unique case (mode_q)
				MODE_STRING: begin
					cnt_d = sat_inc(cnt_q);
					if (char_s1 == CH_QUOTE) begin
						slot_a.valid = 1'b1;
						slot_a.tok   = mk_tok(KIND_STRING, 5'd0, begin_q, cnt_d);
						mode_d       = MODE_IDLE;
					end
					done = 1'b1;
				end
				MODE_WORD: begin
					if (is_letter || is_digit) begin
						alive_d = match_alive(alive_q, cnt_q, char_s1);
						cnt_d   = sat_inc(cnt_q);
						done    = 1'b1;
					end else begin
						slot_a = flush_tok(mode_q, begin_q, cnt_q, alive_q);
						mode_d = MODE_IDLE;
					end
				end
				MODE_NUMBER: begin
					if (is_digit) begin
						cnt_d = sat_inc(cnt_q);
						done  = 1'b1;
					end else if (is_letter) begin
						slot_a.valid = 1'b1;
						slot_a.tok   = mk_tok(KIND_ERROR, 5'd0, pos_q, CW'(1));
						mode_d       = MODE_HALT;
						done         = 1'b1;
					end else begin
						slot_a = flush_tok(mode_q, begin_q, cnt_q, alive_q);
						mode_d = MODE_IDLE;
					end
				end
				MODE_LT, MODE_GT, MODE_COLON: begin
					if (pair_hit) begin
						slot_a.valid = 1'b1;
						slot_a.tok   = mk_tok(KIND_PUNCT, pair_code, begin_q, CW'(2));
						mode_d       = MODE_IDLE;
						done         = 1'b1;
					end else begin
						slot_a = flush_tok(mode_q, begin_q, cnt_q, alive_q);
						mode_d = MODE_IDLE;
					end
				end
				MODE_IDLE, MODE_HALT: ;
			endcase

			if (!done) begin
				priority if (char_s1 == CH_SPACE || char_s1 == CH_LF) begin
				end else if (char_s1 == CH_QUOTE) begin
					mode_d  = MODE_STRING;
					begin_d = pos_q;
					cnt_d   = CW'(1);
				end else if (is_letter) begin
					alive_d = match_alive(ALIVE_ALL, CW'(0), char_s1);
					mode_d  = MODE_WORD;
					begin_d = pos_q;
					cnt_d   = CW'(1);
				end else if (is_digit) begin
					mode_d  = MODE_NUMBER;
					begin_d = pos_q;
					cnt_d   = CW'(1);
				end else if (char_s1 == CH_LT) begin
					mode_d  = MODE_LT;
					begin_d = pos_q;
					cnt_d   = CW'(1);
				end else if (char_s1 == CH_GT) begin
					mode_d  = MODE_GT;
					begin_d = pos_q;
					cnt_d   = CW'(1);
				end else if (char_s1 == CH_COLON) begin
					mode_d  = MODE_COLON;
					begin_d = pos_q;
					cnt_d   = CW'(1);
				end else if (pl.valid) begin
					slot_b.valid = 1'b1;
					slot_b.tok   = mk_tok(KIND_PUNCT, pl.code, pos_q, CW'(1));
				end else begin
					slot_b.valid = 1'b1;
					slot_b.tok   = mk_tok(KIND_ERROR, 5'd0, pos_q, CW'(1));
					mode_d       = MODE_HALT;
				end
			end

			if (eot_s1 && mode_d != MODE_HALT) begin
				if (mode_d == MODE_STRING) begin
					slot_c.valid = 1'b1;
					slot_c.tok   = mk_tok(KIND_ERROR, 5'd0, begin_d, cnt_d);
					mode_d       = MODE_HALT;
				end else begin
					slot_c = flush_tok(mode_d, begin_d, cnt_d, alive_d);
					mode_d = MODE_IDLE;
				end
			end

			pos_d = eot_s1 ? '0 : pos_q + PB'(1);
		end
	end

	// pack the up to two results in order
	always_comb begin
		first_e.tok   = slot_a.valid ? slot_a.tok : (slot_b.valid ? slot_b.tok : slot_c.tok);
		second_e.tok  = (slot_a.valid && slot_b.valid) ? slot_b.tok : slot_c.tok;
		n_push        = 2'(slot_a.valid) + 2'(slot_b.valid) + 2'(slot_c.valid);
		first_e.last  = (n_push == 2'd1);
		second_e.last = 1'b1;
	end

	// room for the word in the scan stage and for the one being accepted
	assign s_tready = (RDYW'(count_q) + (valid_s1 ? RDYW'(2) : RDYW'(0)))
		<= RDYW'(FIFO_DEPTH - 2);

	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {head.tok.length, head.tok.start, head.tok.code, head.tok.kind};
	assign m_tlast  = head.last;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			begin_q  <= '0;
			cnt_q    <= '0;
			alive_q  <= ALIVE_ALL;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
			if (valid_s1) begin
				mode_q   <= mode_d;
				pos_q    <= pos_d;
				begin_q  <= begin_d;
				cnt_q    <= cnt_d;
				alive_q  <= alive_d;
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(n_push);
			end
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + (valid_s1 ? CNTW'(n_push) : CNTW'(0)) - CNTW'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eot_s1  <= s_tlast;
		end
		if (valid_s1 && n_push != 2'd0)
			fifo_q[wr_ptr_q] <= first_e;
		if (valid_s1 && n_push == 2'd2)
			fifo_q[wr_ptr_q + FIFO_AW'(1)] <= second_e;
	end

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(FIFO_DEPTH))
		else $error("result queue count beyond depth");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (RDYW'(count_q) + RDYW'(2)) <= RDYW'(FIFO_DEPTH))
		else $error("scan stage may overflow the result queue");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_HALT |=> mode_q == MODE_HALT)
		else $error("scanner left the halted mode without reset");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> valid_s1)
		else $error("accepted word did not reach the scan stage");

endmodule

`default_nettype wire
